FILE: rtl/lpd_pkg.sv
// ============================================================================
// Loss plateau detector package
// Shared widths, register indexes and reset values of the plateau detector.
// ============================================================================
`default_nettype none

package lpd_pkg;

    localparam int unsigned LOSS_W         = 32;
    localparam int unsigned WINDOW_DEFAULT = 10;
    localparam int unsigned ROOT_W         = 32;
    localparam int unsigned VAR_W          = 2 * ROOT_W;
    localparam int unsigned SQRT_REM_W     = ROOT_W + 4;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOSS     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_THRESHOLD = 8'd1;

    localparam logic [LOSS_W-1:0] TARGET_LOSS_RESET     = 32'd0;
    localparam logic [LOSS_W-1:0] SHAKE_THRESHOLD_RESET = 32'd66;

endpackage

`default_nettype wire

FILE: rtl/loss_plateau_detector.sv
// ============================================================================
// Loss plateau detector
// Sliding-window population standard deviation of epoch losses, with stop
// and weight-shake flags.
// ============================================================================
// Usage:
// Each transaction on the loss channel (loss_valid, loss_stall, epoch_loss)
// carries one Q16.16 epoch loss and yields exactly one transaction on the
// result channel (std_dev, dev_valid, below_target, shake). The block raises
// loss_stall from the cycle after a transaction until its result has been
// loaded into the output register, so one loss is in work at a time.
// A loss below the target, or one that leaves fewer than two losses held,
// goes straight to the done state. Otherwise the block walks the window (one
// read and one 32x32 square per held loss), forms n*sum(x^2) - sum(x)^2 by
// shift-add, divides it by n^2 with a restoring division and takes its square
// root, where n is the number of held losses. The result register holds a
// valid result while result_stall is high; the block may finish the next
// loss meanwhile but waits there until the register is free. Reset empties
// the window, clears the kept deviation and loads the register defaults.
// Configuration writes are taken in every cycle.
// ============================================================================
`default_nettype none

module loss_plateau_detector #(
    parameter int unsigned WINDOW = lpd_pkg::WINDOW_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           loss_valid,
    output logic                                loss_stall,
    input  wire logic [lpd_pkg::LOSS_W-1:0]     epoch_loss,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [lpd_pkg::LOSS_W-1:0]          std_dev,
    output logic                                dev_valid,
    output logic                                below_target,
    output logic                                shake,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lpd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned LOSS_W = lpd_pkg::LOSS_W;
    localparam int unsigned ROOT_W = lpd_pkg::ROOT_W;
    localparam int unsigned VAR_W  = lpd_pkg::VAR_W;
    localparam int unsigned SRW    = lpd_pkg::SQRT_REM_W;
    localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
    localparam int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned SUM_W  = LOSS_W + CNT_W;
    localparam int unsigned SQ_W   = 2 * LOSS_W + CNT_W;
    localparam int unsigned NUM_W  = 2 * LOSS_W + 2 * CNT_W;
    localparam int unsigned DIV_W  = 2 * CNT_W;
    localparam int unsigned STEP_W = $clog2(NUM_W);

    localparam logic [CNT_W-1:0]  WIN_FULL     = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0]  MIN_HELD     = CNT_W'(2);
    localparam logic [IDX_W-1:0]  WIN_LAST_IDX = IDX_W'(WINDOW - 1);
    localparam logic [STEP_W-1:0] MULS_FIRST   = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] DIV_FIRST    = STEP_W'(NUM_W - 1);
    localparam logic [STEP_W-1:0] SQRT_FIRST   = STEP_W'(ROOT_W - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_WALK = 6'b000010,
        ST_MULS = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [LOSS_W-1:0]        target_reg, target_next;
    logic [LOSS_W-1:0]        thresh_reg, thresh_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [IDX_W-1:0]         slot_reg, slot_next;
    logic [ROOT_W-1:0]        dev_reg, dev_next;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic                     sq_vld_reg, sq_vld_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     result_valid_reg, result_valid_next;

    logic [LOSS_W-1:0]        window_mem [WINDOW];
    logic [LOSS_W-1:0]        rd_data_reg;
    logic [2*LOSS_W-1:0]      sq_reg, sq_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [SQ_W-1:0]          qsum_reg, qsum_next;
    logic [SUM_W-1:0]         sbits_reg, sbits_next;
    logic [SUM_W-1:0]         nbits_reg, nbits_next;
    logic [DIV_W-1:0]         div_reg, div_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [SRW-1:0]           srem_reg, srem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic                     stop_reg, stop_next;
    logic [LOSS_W-1:0]        std_dev_reg, std_dev_next;
    logic                     dev_valid_reg, dev_valid_next;
    logic                     below_reg, below_next;
    logic                     shake_reg, shake_next;

    logic                     loss_acc;
    logic                     cfg_wr;
    logic                     mem_wr;
    logic                     rd_issue;
    logic [DIV_W:0]           rem_shift;
    logic                     div_ge;
    logic [SRW-1:0]           srem_shift;
    logic [SRW-1:0]           sqrt_trial;
    logic                     sqrt_ge;

    assign loss_stall   = (state_reg != ST_IDLE);
    assign loss_acc     = loss_valid && !loss_stall;
    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign result_valid = result_valid_reg;
    assign std_dev      = std_dev_reg;
    assign dev_valid    = dev_valid_reg;
    assign below_target = below_reg;
    assign shake        = shake_reg;

    assign rem_shift  = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge     = (rem_shift >= {1'b0, div_reg});
    assign srem_shift = {srem_reg[SRW-3:0], num_reg[VAR_W-1 -: 2]};
    assign sqrt_trial = SRW'({root_reg, 2'b01});
    assign sqrt_ge    = (srem_shift >= sqrt_trial);

    always_comb
    begin
        state_next        = state_reg;
        target_next       = target_reg;
        thresh_next       = thresh_reg;
        fill_next         = fill_reg;
        slot_next         = slot_reg;
        dev_next          = dev_reg;
        rd_idx_next       = rd_idx_reg;
        rd_vld_next       = 1'b0;
        sq_vld_next       = 1'b0;
        step_next         = step_reg;
        result_valid_next = result_valid_reg;
        sq_next           = sq_reg;
        sum_next          = sum_reg;
        qsum_next         = qsum_reg;
        sbits_next        = sbits_reg;
        nbits_next        = nbits_reg;
        div_next          = div_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        srem_next         = srem_reg;
        root_next         = root_reg;
        stop_next         = stop_reg;
        std_dev_next      = std_dev_reg;
        dev_valid_next    = dev_valid_reg;
        below_next        = below_reg;
        shake_next        = shake_reg;
        mem_wr            = 1'b0;
        rd_issue          = 1'b0;

        if (cfg_wr)
        begin
            case (cfg_index)
                lpd_pkg::REG_TARGET_LOSS:     target_next = cfg_data;
                lpd_pkg::REG_SHAKE_THRESHOLD: thresh_next = cfg_data;
                default: ;
            endcase
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (loss_acc)
                begin
                    stop_next = (epoch_loss < target_reg);
                    if (epoch_loss < target_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_wr    = 1'b1;
                        slot_next = (slot_reg == WIN_LAST_IDX) ? '0 : slot_reg + 1'b1;
                        fill_next = (fill_reg == WIN_FULL) ? fill_reg : fill_reg + 1'b1;
                        rd_idx_next = '0;
                        sum_next    = '0;
                        qsum_next   = '0;
                        state_next  = (fill_next >= MIN_HELD) ? ST_WALK : ST_DONE;
                    end
                end
            end
            ST_WALK:
            begin
                rd_issue    = (rd_idx_reg != fill_reg);
                rd_vld_next = rd_issue;
                if (rd_issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    sum_next    = sum_reg + SUM_W'(rd_data_reg);
                    sq_next     = rd_data_reg * rd_data_reg;
                    sq_vld_next = 1'b1;
                end
                if (sq_vld_reg)
                begin
                    qsum_next = qsum_reg + SQ_W'(sq_reg);
                end
                if (!rd_issue && !rd_vld_reg && !sq_vld_reg)
                begin
                    div_next   = DIV_W'(fill_reg) * DIV_W'(fill_reg);
                    sbits_next = sum_reg;
                    nbits_next = SUM_W'(fill_reg);
                    num_next   = '0;
                    step_next  = MULS_FIRST;
                    state_next = ST_MULS;
                end
            end
            ST_MULS:
            begin
                num_next = (num_reg << 1)
                         + (nbits_reg[SUM_W-1] ? NUM_W'(qsum_reg) : '0)
                         - (sbits_reg[SUM_W-1] ? NUM_W'(sum_reg) : '0);
                sbits_next = sbits_reg << 1;
                nbits_next = nbits_reg << 1;
                if (step_reg == '0)
                begin
                    rem_next   = '0;
                    step_next  = DIV_FIRST;
                    state_next = ST_DIV;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? DIV_W'(rem_shift - {1'b0, div_reg}) : DIV_W'(rem_shift);
                num_next = {num_reg[NUM_W-2:0], div_ge};
                if (step_reg == '0)
                begin
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = SQRT_FIRST;
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_SQRT:
            begin
                srem_next = sqrt_ge ? (srem_shift - sqrt_trial) : srem_shift;
                root_next = {root_reg[ROOT_W-2:0], sqrt_ge};
                num_next  = {num_reg[NUM_W-1:VAR_W], num_reg[VAR_W-3:0], 2'b00};
                if (step_reg == '0)
                begin
                    dev_next   = root_next;
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    std_dev_next      = dev_reg;
                    dev_valid_next    = (fill_reg >= MIN_HELD);
                    below_next        = stop_reg;
                    shake_next        = !stop_reg && (dev_reg != '0) && (dev_reg < thresh_reg);
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            target_reg       <= lpd_pkg::TARGET_LOSS_RESET;
            thresh_reg       <= lpd_pkg::SHAKE_THRESHOLD_RESET;
            fill_reg         <= '0;
            slot_reg         <= '0;
            dev_reg          <= '0;
            rd_idx_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            sq_vld_reg       <= 1'b0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            target_reg       <= target_next;
            thresh_reg       <= thresh_next;
            fill_reg         <= fill_next;
            slot_reg         <= slot_next;
            dev_reg          <= dev_next;
            rd_idx_reg       <= rd_idx_next;
            rd_vld_reg       <= rd_vld_next;
            sq_vld_reg       <= sq_vld_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg        <= sq_next;
        sum_reg       <= sum_next;
        qsum_reg      <= qsum_next;
        sbits_reg     <= sbits_next;
        nbits_reg     <= nbits_next;
        div_reg       <= div_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        srem_reg      <= srem_next;
        root_reg      <= root_next;
        stop_reg      <= stop_next;
        std_dev_reg   <= std_dev_next;
        dev_valid_reg <= dev_valid_next;
        below_reg     <= below_next;
        shake_reg     <= shake_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            window_mem[slot_reg] <= epoch_loss;
        end
        if (rd_issue)
        begin
            rd_data_reg <= window_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= WIN_FULL)
        else $error("Fill count exceeds the window depth.");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= WIN_LAST_IDX)
        else $error("Write slot is outside the window.");

    a_stop_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (loss_acc && (epoch_loss < target_reg)) |=> $stable(fill_reg))
        else $error("A loss below target changed the window fill.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("Result became valid outside the final state.");

    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SQRT) && $past(state_reg == ST_DIV))
            |-> (num_reg[NUM_W-1:VAR_W] == '0))
        else $error("Variance quotient does not fit the root input.");

endmodule

`default_nettype wire
